### rtl/core/jer_pkg.sv
// Shared constants, types and controller/datapath interfaces of the elimination ring.
package jer_pkg;

   localparam int MAX_MEMBERS = 1024;
   localparam int IDX_W       = $clog2(MAX_MEMBERS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int LEN_W       = 11;
   localparam int SKIP_W      = 16;
   localparam int MEMBER_W    = 11;
   localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int DCNT_W      = $clog2(SKIP_W);
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [LEN_W-1:0]  RING_LENGTH_RESET = LEN_W'(1024);
   localparam logic [SKIP_W-1:0] SKIP_COUNT_RESET  = SKIP_W'(1);

   localparam logic REG_RING_LENGTH = 1'b0;
   localparam logic REG_SKIP_COUNT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_CHECK,
      ST_DIVIDE,
      ST_PRIME,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic fill_init;
      logic fill_write;
      logic div_init;
      logic div_step;
      logic walk;
      logic emit_over;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic game_over;
      logic div_last;
      logic steps_zero;
   } stat_type;

endpackage

### rtl/core/jer_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jer_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/jer_dpath.sv
// Datapath: ring link memory, position registers, remainder unit and result registers.
module jer_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  jer_pkg::cmd_type          cmd,
   output jer_pkg::stat_type         stat,
   input  logic [jer_pkg::LEN_W-1:0] ring_length,
   input  logic [jer_pkg::SKIP_W-1:0] skip_count,
   output logic                      rsp_valid,
   output logic [jer_pkg::MEMBER_W-1:0] rsp_member,
   output logic                      rsp_status,
   output logic                      rsp_last,
   output logic [jer_pkg::MEMBER_W-1:0] rsp_survivor
);
   import jer_pkg::*;

   logic [CNT_W-1:0]    len_n_ff, len_n_in;
   logic [IDX_W-1:0]    fill_idx_ff, fill_idx_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    prev_ff, prev_in;
   logic [CNT_W-1:0]    remaining_ff, remaining_in;
   logic [SKIP_W-1:0]   dividend_ff, dividend_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MEMBER_W-1:0] member_ff, member_in;
   logic                status_ff, status_in;
   logic                last_ff, last_in;
   logic [MEMBER_W-1:0] survivor_ff, survivor_in;

   logic [CMP_W-1:0]    len_ext;
   logic [CNT_W-1:0]    len_clamped;
   logic [CNT_W-1:0]    shifted;
   logic                fill_last;
   logic                steps_zero;
   logic                commit;
   logic [IDX_W-1:0]    fill_data;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [IDX_W-1:0]    ram_wr_data;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [IDX_W-1:0]    ram_rd_data;
   logic [CNT_W-1:0]    cur_number;
   logic [CNT_W-1:0]    succ_number;

   // A ring length of zero counts as one member; anything above the capacity is capped.
   always_comb begin
      len_ext = CMP_W'(ring_length);
      if (ring_length == '0) begin
         len_clamped = CNT_W'(1);
      end else if (len_ext > CMP_W'(MAX_MEMBERS)) begin
         len_clamped = CNT_W'(MAX_MEMBERS);
      end else begin
         len_clamped = CNT_W'(ring_length);
      end
   end

   assign fill_last   = ({1'b0, fill_idx_ff} == (len_n_ff - CNT_W'(1)));
   assign fill_data   = fill_last ? '0 : (fill_idx_ff + IDX_W'(1));
   assign steps_zero  = (rem_ff == '0);
   assign commit      = cmd.walk && steps_zero;
   assign shifted     = {rem_ff[CNT_W-2:0], dividend_ff[SKIP_W-1]};
   assign cur_number  = {1'b0, cur_ff} + CNT_W'(1);
   assign succ_number = {1'b0, ram_rd_data} + CNT_W'(1);

   assign stat.fill_last  = fill_last;
   assign stat.game_over  = (remaining_ff <= CNT_W'(1));
   assign stat.div_last   = (div_cnt_ff == '0);
   assign stat.steps_zero = steps_zero;

   // While walking, the read data already holds the successor, so the next read follows it
   // straight away and the walk advances one link every cycle.
   assign ram_rd_addr = (cmd.walk && !steps_zero) ? ram_rd_data : cur_ff;
   assign ram_wr_en   = cmd.fill_write || commit;
   assign ram_wr_addr = cmd.fill_write ? fill_idx_ff : prev_ff;
   assign ram_wr_data = cmd.fill_write ? fill_data : ram_rd_data;

   jer_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_MEMBERS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      len_n_in     = len_n_ff;
      fill_idx_in  = fill_idx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      remaining_in = remaining_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = 1'b0;
      member_in    = member_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      survivor_in  = survivor_ff;

      if (cmd.fill_init) begin
         len_n_in    = len_clamped;
         fill_idx_in = '0;
      end

      if (cmd.fill_write) begin
         fill_idx_in = fill_idx_ff + IDX_W'(1);
         if (fill_last) begin
            cur_in       = '0;
            prev_in      = IDX_W'(len_n_ff - CNT_W'(1));
            remaining_in = len_n_ff;
         end
      end

      // Restoring remainder of the skip count by the members remaining, one bit a cycle.
      if (cmd.div_init) begin
         dividend_in = skip_count;
         rem_in      = '0;
         div_cnt_in  = DCNT_W'(SKIP_W - 1);
      end

      if (cmd.div_step) begin
         dividend_in = {dividend_ff[SKIP_W-2:0], 1'b0};
         div_cnt_in  = div_cnt_ff - DCNT_W'(1);
         if (shifted >= remaining_ff) begin
            rem_in = shifted - remaining_ff;
         end else begin
            rem_in = shifted;
         end
      end

      if (cmd.walk) begin
         if (!steps_zero) begin
            prev_in = cur_ff;
            cur_in  = ram_rd_data;
            rem_in  = rem_ff - CNT_W'(1);
         end else begin
            cur_in       = ram_rd_data;
            remaining_in = remaining_ff - CNT_W'(1);
            rsp_valid_in = 1'b1;
            member_in    = MEMBER_W'(cur_number);
            status_in    = 1'b0;
            last_in      = (remaining_ff == CNT_W'(2));
            survivor_in  = (remaining_ff == CNT_W'(2)) ? MEMBER_W'(succ_number) : '0;
         end
      end

      if (cmd.emit_over) begin
         rsp_valid_in = 1'b1;
         status_in    = 1'b1;
         if (remaining_ff == CNT_W'(1)) begin
            member_in   = MEMBER_W'(cur_number);
            last_in     = 1'b1;
            survivor_in = MEMBER_W'(cur_number);
         end else begin
            member_in   = '0;
            last_in     = 1'b0;
            survivor_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         prev_ff      <= IDX_W'(MAX_MEMBERS - 1);
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_n_ff    <= len_n_in;
      fill_idx_ff <= fill_idx_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      member_ff   <= member_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      survivor_ff <= survivor_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_member   = member_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;
   assign rsp_survivor = survivor_ff;

endmodule

### rtl/core/jer_ctrl.sv
// Controller state machine sequencing refill, remainder, walk and result.
module jer_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_restart,
   output logic              busy,
   input  jer_pkg::stat_type stat,
   output jer_pkg::cmd_type  cmd
);
   import jer_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = req_restart ? ST_FILL : ST_CHECK;
            end
         end
         ST_FILL: begin
            if (stat.fill_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.game_over ? ST_IDLE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (stat.steps_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.fill_init = start && req_restart;
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
         end
         ST_CHECK: begin
            cmd.emit_over = stat.game_over;
            cmd.div_init  = !stat.game_over;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_PRIME: begin
            // The link of the current member is read during this cycle.
            cmd = '0;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/core/josephus_elimination_ring_core.sv
// Josephus elimination ring: register file, controller and datapath.
// Sequence from the accepting edge: a restart first rebuilds the links, one member of the clamped
// ring length per cycle; then come the check state, the remainder, the read state and a walk
// over (skip mod remaining) links that removes the member reached, and the strobe is registered.
// A step after the game has ended answers from the check state alone. Throughput: one step at
// a time; the next start is taken in the cycle of the strobe, and the receiver never stalls.
// Reset clears the controller and leaves no game; the link memory is rebuilt at each restart.
module josephus_elimination_ring_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   output logic [jer_pkg::MEMBER_W-1:0]  rsp_member,
   output logic                          rsp_status,
   output logic                          rsp_last,
   output logic [jer_pkg::MEMBER_W-1:0]  rsp_survivor,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [jer_pkg::ADDR_W-1:0]    paddr,
   input  logic [jer_pkg::DATA_W-1:0]    pwdata,
   output logic [jer_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import jer_pkg::*;

   logic [LEN_W-1:0]  ring_length_ff, ring_length_in;
   logic [SKIP_W-1:0] skip_count_ff, skip_count_in;
   logic              csr_write;
   cmd_type           cmd;
   stat_type          stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      ring_length_in = ring_length_ff;
      skip_count_in  = skip_count_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_RING_LENGTH: ring_length_in = pwdata[LEN_W-1:0];
            REG_SKIP_COUNT:  skip_count_in  = pwdata[SKIP_W-1:0];
            default:         ring_length_in = ring_length_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_RING_LENGTH: prdata = DATA_W'(ring_length_ff);
         REG_SKIP_COUNT:  prdata = DATA_W'(skip_count_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff <= RING_LENGTH_RESET;
         skip_count_ff  <= SKIP_COUNT_RESET;
      end else begin
         ring_length_ff <= ring_length_in;
         skip_count_ff  <= skip_count_in;
      end
   end

   jer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_restart (req_restart),
      .busy        (busy),
      .stat        (stat),
      .cmd         (cmd)
   );

   jer_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .ring_length  (ring_length_ff),
      .skip_count   (skip_count_ff),
      .rsp_valid    (rsp_valid),
      .rsp_member   (rsp_member),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .rsp_survivor (rsp_survivor)
   );

   // A result transfer is always produced by a step that was in progress in the cycle before.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(busy))
      else $error("result strobe without a step in progress");

   // The strobe marks a single cycle per step.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted step keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted step did not start");

   // An eliminated member is always numbered from one upwards.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_status) |-> (rsp_member != '0))
      else $error("eliminated member number is zero");

   // A final result always names a survivor.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_last) |-> (rsp_survivor != '0))
      else $error("last result without survivor");

endmodule
